FILE: rtl/dri_pkg.sv
// Shared types, constants and tables of the dead-reckoning integrator.
package dri_pkg;

    // Default values for the top level parameters
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int POS_BITS_DEF     = 40;
    localparam int ANGLE_BITS_DEF   = 16;

    // Field widths
    localparam int OP_W      = 2;
    localparam int TIME_W    = 32;
    localparam int MOTION_W  = 3;
    localparam int OUT_W     = 40;
    localparam int HEAD_OUT_W = 16;
    localparam int UNC_W     = 48;
    localparam int HEADING_W = 32;
    localparam int SPEED_W   = 20;
    localparam int TURN_W    = 32;
    localparam int DRIFT_W   = 16;
    localparam int TDRIFT_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int DIST_W    = TIME_W + SPEED_W - 8;
    localparam int TRIG_W    = 16;
    localparam int CORD_W    = 34;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;

    // Operations
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Motion codes
    localparam logic [MOTION_W-1:0] MOT_STOP  = 3'd0;
    localparam logic [MOTION_W-1:0] MOT_FWD   = 3'd1;
    localparam logic [MOTION_W-1:0] MOT_BACK  = 3'd2;
    localparam logic [MOTION_W-1:0] MOT_LEFT  = 3'd3;
    localparam logic [MOTION_W-1:0] MOT_RIGHT = 3'd4;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TDRIFT = 2'd3;
    localparam logic [SPEED_W-1:0]  SPEED_RST  = 20'd1966;
    localparam logic [TURN_W-1:0]   TURN_RST   = 32'd1073742;
    localparam logic [DRIFT_W-1:0]  DRIFT_RST  = 16'd3277;
    localparam logic [TDRIFT_W-1:0] TDRIFT_RST = 24'd65536;

    // CORDIC start value, 0.6072529350 in Q30
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // atan(2^-i), 2^32 units per turn
    function automatic logic [HEADING_W-1:0] atan_unit(input logic [ATAN_IDX_W-1:0] idx);
        logic [HEADING_W-1:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic restart;
        logic set_time;
        logic dist_mul;
        logic cordic_step;
        logic trig;
        logic prod;
        logic move;
        logic turn_mul;
        logic head;
        logic unc_mul;
        logic unc_sum;
        logic set_motion;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic                started;
        logic                dt_ok;
        logic [MOTION_W-1:0] motion;
        logic [OP_W-1:0]     op;
        logic [MOTION_W-1:0] new_motion;
        logic                cordic_last;
    } t_dp_status;

endpackage

FILE: rtl/dri_if.sv
// Request channels of the dead-reckoning integrator.
interface dri_item_if;
    logic                              valid;
    logic                              ready;
    logic [dri_pkg::OP_W-1:0]          op;
    logic [dri_pkg::TIME_W-1:0]        now_ms;
    logic [dri_pkg::MOTION_W-1:0]      new_motion;
    modport source (output valid, op, now_ms, new_motion, input ready);
    modport sink   (input valid, op, now_ms, new_motion, output ready);
endinterface

interface dri_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [dri_pkg::OUT_W-1:0]    x_position;
    logic signed [dri_pkg::OUT_W-1:0]    y_position;
    logic [dri_pkg::HEAD_OUT_W-1:0]      heading_angle;
    logic [dri_pkg::OUT_W-1:0]           path_length;
    logic [dri_pkg::OUT_W-1:0]           turn_time;
    logic [dri_pkg::UNC_W-1:0]           uncertainty;
    logic [dri_pkg::MOTION_W-1:0]        current_motion;
    modport source (output valid, x_position, y_position, heading_angle, path_length,
                    turn_time, uncertainty, current_motion, input ready);
    modport sink   (input valid, x_position, y_position, heading_angle, path_length,
                    turn_time, uncertainty, current_motion, output ready);
endinterface

interface dri_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dri_pkg::CFG_IDX_W-1:0]  index;
    logic [dri_pkg::CFG_DAT_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/dri_datapath.sv
// Datapath: state, configuration, CORDIC unit, multipliers and result register.
module dri_datapath #(
    parameter int CORDIC_STEPS = dri_pkg::CORDIC_STEPS_DEF,
    parameter int POS_BITS     = dri_pkg::POS_BITS_DEF,
    parameter int ANGLE_BITS   = dri_pkg::ANGLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dri_pkg::t_dp_cmd                   i_cmd,
    output dri_pkg::t_dp_status                o_status,
    input  logic [dri_pkg::OP_W-1:0]           i_op,
    input  logic [dri_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [dri_pkg::MOTION_W-1:0]       i_new_motion,
    input  logic                               i_cfg_we,
    input  logic [dri_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dri_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    output logic [dri_pkg::OUT_W-1:0]          o_x_position,
    output logic [dri_pkg::OUT_W-1:0]          o_y_position,
    output logic [dri_pkg::HEAD_OUT_W-1:0]     o_heading_angle,
    output logic [dri_pkg::OUT_W-1:0]          o_path_length,
    output logic [dri_pkg::OUT_W-1:0]          o_turn_time,
    output logic [dri_pkg::UNC_W-1:0]          o_uncertainty,
    output logic [dri_pkg::MOTION_W-1:0]       o_current_motion
);
    localparam int ITERS  = (CORDIC_STEPS < dri_pkg::ATAN_ENTRIES) ?
                            CORDIC_STEPS : dri_pkg::ATAN_ENTRIES;
    localparam int ITER_W = $clog2(ITERS);
    localparam int CW     = dri_pkg::CORD_W;
    localparam int PROD_W = dri_pkg::DIST_W + dri_pkg::TRIG_W - 15;
    localparam int U1_W   = POS_BITS;
    localparam int U2_W   = POS_BITS + dri_pkg::TDRIFT_W - 16;
    localparam int SUM_W  = (U2_W + 1 > dri_pkg::UNC_W + 1) ? U2_W + 1 : dri_pkg::UNC_W + 1;
    localparam int LOW_W  = 32 - ANGLE_BITS;

    // Configuration
    logic [dri_pkg::SPEED_W-1:0]  r_speed;
    logic [dri_pkg::TURN_W-1:0]   r_turn;
    logic [dri_pkg::DRIFT_W-1:0]  r_drift;
    logic [dri_pkg::TDRIFT_W-1:0] r_tdrift;

    // Architectural state
    logic [POS_BITS-1:0]              r_pos_x, r_pos_y, r_path, r_turn_acc;
    logic [dri_pkg::HEADING_W-1:0]    r_heading;
    logic [dri_pkg::TIME_W-1:0]       r_last;
    logic [dri_pkg::MOTION_W-1:0]     r_motion;
    logic                             r_started;

    // Item and working registers
    logic [dri_pkg::OP_W-1:0]         r_op;
    logic [dri_pkg::TIME_W-1:0]       r_now, r_dt;
    logic [dri_pkg::MOTION_W-1:0]     r_new_motion;
    logic [dri_pkg::DIST_W-1:0]       r_dist;
    logic signed [CW-1:0]             r_cx, r_cy, r_cz;
    logic [ITER_W-1:0]                r_iter;
    logic                             r_flip;
    logic [dri_pkg::TRIG_W-1:0]       r_cmag, r_smag;
    logic                             r_cneg, r_sneg;
    logic [POS_BITS-1:0]              r_dx, r_dy;
    logic [dri_pkg::HEADING_W-1:0]    r_dh;
    logic [U1_W-1:0]                  r_u1;
    logic [U2_W-1:0]                  r_u2;
    logic [dri_pkg::UNC_W-1:0]        r_unc;

    // Combinational helpers
    logic [dri_pkg::TIME_W+dri_pkg::SPEED_W-1:0]   dist_full;
    logic [dri_pkg::TIME_W+dri_pkg::TURN_W-1:0]    dh_full;
    logic [dri_pkg::HEADING_W-1:0]                 ang_a;
    logic signed [CW-1:0]                          atan_s, sh_x, sh_y;
    logic signed [CW:0]                            cx_f, cy_f, cx_r, cy_r;
    logic signed [CW-15:0]                         cq, sq;
    logic [dri_pkg::TRIG_W-1:0]                    cmag, smag;
    logic [PROD_W+15-1:0]                          px_full, py_full;
    logic [PROD_W-1:0]                             px, py;
    logic [POS_BITS+dri_pkg::DRIFT_W-1:0]          u1_full;
    logic [POS_BITS+dri_pkg::TDRIFT_W-1:0]         u2_full;
    logic [SUM_W-1:0]                              unc_sum;

    // Status to the controller
    assign o_status.started     = r_started;
    assign o_status.dt_ok       = (r_dt != '0) && !r_dt[dri_pkg::TIME_W-1];
    assign o_status.motion      = r_motion;
    assign o_status.op          = r_op;
    assign o_status.new_motion  = r_new_motion;
    assign o_status.cordic_last = (r_iter == ITER_W'(ITERS - 1));

    // Products and CORDIC arithmetic
    assign dist_full = r_dt * r_speed;
    assign dh_full   = r_dt * r_turn;
    assign ang_a     = {r_heading[31 -: ANGLE_BITS], {LOW_W{1'b0}}};
    assign atan_s    = $signed({2'b00, dri_pkg::atan_unit(dri_pkg::ATAN_IDX_W'(r_iter))});
    assign sh_x      = r_cx >>> r_iter;
    assign sh_y      = r_cy >>> r_iter;

    // Round to Q1.15 after the quadrant fold, then clamp
    function automatic logic signed [CW-15:0] q15(input logic signed [CW:0] v);
        logic signed [CW:0] t;
        t = (v + (CW+1)'(16384)) >>> 15;
        if (t > (CW+1)'(32767))
            t = (CW+1)'(32767);
        else if (t < -(CW+1)'(32768))
            t = -(CW+1)'(32768);
        return t[CW-15:0];
    endfunction

    assign cx_f = {r_cx[CW-1], r_cx};
    assign cy_f = {r_cy[CW-1], r_cy};
    assign cx_r = r_flip ? -cx_f : cx_f;
    assign cy_r = r_flip ? -cy_f : cy_f;
    assign cq   = q15(cx_r);
    assign sq   = q15(cy_r);
    assign cmag = dri_pkg::TRIG_W'(cq[CW-15] ? -cq : cq);
    assign smag = dri_pkg::TRIG_W'(sq[CW-15] ? -sq : sq);

    assign px_full = r_dist * r_cmag;
    assign py_full = r_dist * r_smag;
    assign px      = PROD_W'(px_full >> 15);
    assign py      = PROD_W'(py_full >> 15);

    assign u1_full = r_drift * r_path;
    assign u2_full = r_tdrift * r_turn_acc;
    assign unc_sum = SUM_W'(r_u1) + SUM_W'(r_u2);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= dri_pkg::SPEED_RST;
            r_turn   <= dri_pkg::TURN_RST;
            r_drift  <= dri_pkg::DRIFT_RST;
            r_tdrift <= dri_pkg::TDRIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dri_pkg::REG_SPEED:  r_speed  <= i_cfg_data[dri_pkg::SPEED_W-1:0];
                dri_pkg::REG_TURN:   r_turn   <= i_cfg_data[dri_pkg::TURN_W-1:0];
                dri_pkg::REG_DRIFT:  r_drift  <= i_cfg_data[dri_pkg::DRIFT_W-1:0];
                dri_pkg::REG_TDRIFT: r_tdrift <= i_cfg_data[dri_pkg::TDRIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Odometry state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_path     <= '0;
            r_turn_acc <= '0;
            r_heading  <= '0;
            r_last     <= '0;
            r_motion   <= dri_pkg::MOT_STOP;
            r_started  <= 1'b0;
        end else begin
            if (i_cmd.restart) begin
                r_pos_x    <= '0;
                r_pos_y    <= '0;
                r_path     <= '0;
                r_turn_acc <= '0;
                r_heading  <= '0;
                r_motion   <= dri_pkg::MOT_STOP;
                r_last     <= r_now;
                r_started  <= 1'b1;
            end
            if (i_cmd.set_time)
                r_last <= r_now;
            if (i_cmd.move) begin
                if (r_motion == dri_pkg::MOT_FWD) begin
                    r_pos_x <= r_pos_x + r_dx;
                    r_pos_y <= r_pos_y + r_dy;
                end else begin
                    r_pos_x <= r_pos_x - r_dx;
                    r_pos_y <= r_pos_y - r_dy;
                end
                r_path <= r_path + POS_BITS'(r_dist);
            end
            if (i_cmd.head) begin
                if (r_motion == dri_pkg::MOT_LEFT)
                    r_heading <= r_heading + r_dh;
                else
                    r_heading <= r_heading - r_dh;
                r_turn_acc <= r_turn_acc + POS_BITS'(r_dt);
            end
            if (i_cmd.set_motion)
                r_motion <= r_new_motion;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_op;
            r_now        <= i_now_ms;
            r_new_motion <= i_new_motion;
            r_dt         <= i_now_ms - r_last;
        end
        // distance and CORDIC start, with the quadrant fold
        if (i_cmd.dist_mul) begin
            r_dist <= dri_pkg::DIST_W'(dist_full >> 8);
            r_flip <= ang_a[31] ^ ang_a[30];
            r_cz   <= $signed({{(CW-32){ang_a[30]}}, ang_a[31] ^ ang_a[30] ?
                                {~ang_a[31], ang_a[30:0]} : ang_a});
            r_cx   <= dri_pkg::CORDIC_GAIN_Q30;
            r_cy   <= '0;
            r_iter <= '0;
        end
        if (i_cmd.cordic_step) begin
            if (!r_cz[CW-1]) begin
                r_cx <= r_cx - sh_y;
                r_cy <= r_cy + sh_x;
                r_cz <= r_cz - atan_s;
            end else begin
                r_cx <= r_cx + sh_y;
                r_cy <= r_cy - sh_x;
                r_cz <= r_cz + atan_s;
            end
            r_iter <= r_iter + 1'b1;
        end
        if (i_cmd.trig) begin
            r_cmag <= cmag;
            r_smag <= smag;
            r_cneg <= cq[CW-15];
            r_sneg <= sq[CW-15];
        end
        if (i_cmd.prod) begin
            r_dx <= r_cneg ? -POS_BITS'(px) : POS_BITS'(px);
            r_dy <= r_sneg ? -POS_BITS'(py) : POS_BITS'(py);
        end
        if (i_cmd.turn_mul)
            r_dh <= dri_pkg::HEADING_W'(dh_full >> 16);
        if (i_cmd.unc_mul) begin
            r_u1 <= U1_W'(u1_full >> 16);
            r_u2 <= U2_W'(u2_full >> 16);
        end
        // saturate at the top of the 48-bit range
        if (i_cmd.unc_sum) begin
            if (unc_sum > SUM_W'({dri_pkg::UNC_W{1'b1}}))
                r_unc <= {dri_pkg::UNC_W{1'b1}};
            else
                r_unc <= dri_pkg::UNC_W'(unc_sum);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_x_position     <= dri_pkg::OUT_W'(r_pos_x);
            o_y_position     <= dri_pkg::OUT_W'(r_pos_y);
            o_heading_angle  <= r_heading[31 -: dri_pkg::HEAD_OUT_W];
            o_path_length    <= dri_pkg::OUT_W'(r_path);
            o_turn_time      <= dri_pkg::OUT_W'(r_turn_acc);
            o_uncertainty    <= r_unc;
            o_current_motion <= r_motion;
        end
    end

endmodule

FILE: rtl/dri_ctrl.sv
// Controller: sequences one request through the datapath and owns the request and result handshakes.
module dri_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  dri_pkg::t_dp_status   i_status,
    output dri_pkg::t_dp_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_DIST   = 4'd2;
    localparam logic [3:0] S_CORDIC = 4'd3;
    localparam logic [3:0] S_TRIG   = 4'd4;
    localparam logic [3:0] S_PROD   = 4'd5;
    localparam logic [3:0] S_MOVE   = 4'd6;
    localparam logic [3:0] S_TURN   = 4'd7;
    localparam logic [3:0] S_HEAD   = 4'd8;
    localparam logic [3:0] S_UNC    = 4'd9;
    localparam logic [3:0] S_SUM    = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       straight, turning, slot_free;

    assign straight  = (i_status.motion == dri_pkg::MOT_FWD) ||
                       (i_status.motion == dri_pkg::MOT_BACK);
    assign turning   = (i_status.motion == dri_pkg::MOT_LEFT) ||
                       (i_status.motion == dri_pkg::MOT_RIGHT);
    assign slot_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if ((i_status.op == dri_pkg::OP_RESET) ||
                    ((i_status.op != dri_pkg::OP_NONE) && !i_status.started)) begin
                    o_cmd.restart = 1'b1;
                    n_state       = S_UNC;
                end else if ((i_status.op == dri_pkg::OP_NONE) || !i_status.dt_ok) begin
                    n_state = S_UNC;
                end else begin
                    o_cmd.set_time = 1'b1;
                    if (straight)
                        n_state = S_DIST;
                    else if (turning)
                        n_state = S_TURN;
                    else
                        n_state = S_UNC;
                end
            end
            S_DIST: begin
                o_cmd.dist_mul = 1'b1;
                n_state        = S_CORDIC;
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (i_status.cordic_last)
                    n_state = S_TRIG;
            end
            S_TRIG: begin
                o_cmd.trig = 1'b1;
                n_state    = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_MOVE;
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = S_UNC;
            end
            S_TURN: begin
                o_cmd.turn_mul = 1'b1;
                n_state        = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.head = 1'b1;
                n_state    = S_UNC;
            end
            S_UNC: begin
                o_cmd.unc_mul    = 1'b1;
                o_cmd.set_motion = (i_status.op == dri_pkg::OP_SET) &&
                                   (i_status.new_motion <= dri_pkg::MOT_RIGHT);
                n_state          = S_SUM;
            end
            S_SUM: begin
                o_cmd.unc_sum = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECIDE))
        else $error("accepted request did not start processing");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("result loaded without valid");

    a_cordic_straight_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIST) |-> straight)
        else $error("CORDIC started while not moving straight");

    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.restart, o_cmd.move, o_cmd.head, o_cmd.set_motion}))
        else $error("conflicting state updates");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.out_load)
        else $error("pending result overwritten");
`endif

endmodule

FILE: rtl/dead_reckoning_integrator.sv
// Top level of the dead-reckoning integrator.
// Each request is processed alone; a new one is taken while the previous result
// still waits in the output register. A request that moves the robot straight
// runs through the distance step, the CORDIC unit (one rotation per cycle),
// the trig and product steps and the move; a turning update runs through the
// turn product and heading update. Configuration writes are taken every cycle.
module dead_reckoning_integrator #(
    parameter int CORDIC_STEPS = dri_pkg::CORDIC_STEPS_DEF,
    parameter int POS_BITS     = dri_pkg::POS_BITS_DEF,
    parameter int ANGLE_BITS   = dri_pkg::ANGLE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dri_item_if.sink       i_item,
    dri_result_if.source   o_result,
    dri_cfg_if.sink        i_cfg
);
    dri_pkg::t_dp_cmd    cmd;
    dri_pkg::t_dp_status status;

    assign i_cfg.ready = 1'b1;

    dri_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dri_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .POS_BITS     (POS_BITS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_op             (i_item.op),
        .i_now_ms         (i_item.now_ms),
        .i_new_motion     (i_item.new_motion),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .o_x_position     (o_result.x_position),
        .o_y_position     (o_result.y_position),
        .o_heading_angle  (o_result.heading_angle),
        .o_path_length    (o_result.path_length),
        .o_turn_time      (o_result.turn_time),
        .o_uncertainty    (o_result.uncertainty),
        .o_current_motion (o_result.current_motion)
    );

endmodule

FILE: bench/dri_test_if.sv
// Bench-side note: the channel interfaces come from the RTL; this file holds the bench clock/reset generator.
module dri_clock_gen (
    output logic o_clk,
    output logic o_rst_n
);
    timeunit 1ns;
    timeprecision 1ps;

    // Free-running clock, 20 ns period
    initial o_clk = 1'b0;
    always #10 o_clk = ~o_clk;

    // Reset held low from the start, released at a rising edge
    initial begin
        o_rst_n = 1'b0;
        repeat (7) @(posedge o_clk);
        o_rst_n <= 1'b1;
    end
endmodule

FILE: bench/dead_reckoning_integrator_test.sv
// Self-checking bench: random and directed odometry requests against a behavioural predictor.
module dead_reckoning_integrator_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [dri_pkg::OP_W-1:0]     op;
        logic [dri_pkg::TIME_W-1:0]   now_ms;
        logic [dri_pkg::MOTION_W-1:0] new_motion;
    } t_request;

    typedef struct packed {
        logic [dri_pkg::OUT_W-1:0]      x_pos;
        logic [dri_pkg::OUT_W-1:0]      y_pos;
        logic [dri_pkg::HEAD_OUT_W-1:0] heading;
        logic [dri_pkg::OUT_W-1:0]      path;
        logic [dri_pkg::OUT_W-1:0]      turn_ms;
        logic [dri_pkg::UNC_W-1:0]      unc;
        logic [dri_pkg::MOTION_W-1:0]   motion;
    } t_pose;

    logic i_clk, i_rst_n;
    dri_item_if   item_ch ();
    dri_result_if pose_ch ();
    dri_cfg_if    cfg_ch ();

    dri_clock_gen clkgen (.o_clk(i_clk), .o_rst_n(i_rst_n));

    dead_reckoning_integrator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_result(pose_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Predictor state
    logic [dri_pkg::SPEED_W-1:0]   m_speed;
    logic [dri_pkg::TURN_W-1:0]    m_turn;
    logic [dri_pkg::DRIFT_W-1:0]   m_drift;
    logic [dri_pkg::TDRIFT_W-1:0]  m_tdrift;
    logic [dri_pkg::OUT_W-1:0]     m_x, m_y, m_path, m_turn_ms;
    logic [dri_pkg::HEADING_W-1:0] m_heading;
    logic [dri_pkg::TIME_W-1:0]    m_last;
    logic [dri_pkg::MOTION_W-1:0]  m_motion;
    logic                          m_started;

    t_request pending_requests[$];
    t_pose    expected_poses[$];
    int       n_errors;
    int       n_accepted;
    int       stall_long;
    bit       sending_done;

    logic [dri_pkg::CFG_IDX_W-1:0] cfg_idx_q[$];
    logic [dri_pkg::CFG_DAT_W-1:0] cfg_dat_q[$];

    // Arithmetic shift right rounding toward minus infinity
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint to_q15(longint v);
        longint r;
        r = floor_shr(v + 16384, 15);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    // CORDIC cosine and sine of the heading, Q1.15
    task automatic heading_trig(input logic [31:0] hd, output longint c, output longint s);
        logic [31:0] a;
        logic [31:0] tab [0:15];
        longint x, y, z, dx, dy;
        bit flip;
        tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861};
        a = hd & 32'hFFFF0000;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip) a = a - 32'h80000000;
        z = longint'(signed'(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= tab[i];
            end else begin
                x += dx; y -= dy; z += tab[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = to_q15(x);
        s = to_q15(y);
    endtask

    function automatic logic [63:0] trig_delta(logic [63:0] travel, longint t);
        logic [63:0] mag, p;
        mag = (t < 0) ? 64'(-t) : 64'(t);
        p = (travel * mag) >> 15;
        return (t < 0) ? -p : p;
    endfunction

    task automatic restart_pose(input logic [dri_pkg::TIME_W-1:0] now);
        m_x = '0; m_y = '0; m_path = '0; m_turn_ms = '0;
        m_heading = '0; m_motion = dri_pkg::MOT_STOP;
        m_last = now; m_started = 1'b1;
    endtask

    // Integrate elapsed time under the current motion
    task automatic integrate_motion(input logic [dri_pkg::TIME_W-1:0] now);
        logic [31:0] dt;
        logic [63:0] travel, dh;
        longint c, s;
        if (!m_started) begin
            restart_pose(now);
            return;
        end
        dt = now - m_last;
        if (dt == 0 || dt[31]) return;
        m_last = now;
        if (m_motion == dri_pkg::MOT_FWD || m_motion == dri_pkg::MOT_BACK) begin
            travel = (64'(dt) * 64'(m_speed)) >> 8;
            heading_trig(m_heading, c, s);
            if (m_motion == dri_pkg::MOT_FWD) begin
                m_x = m_x + dri_pkg::OUT_W'(trig_delta(travel, c));
                m_y = m_y + dri_pkg::OUT_W'(trig_delta(travel, s));
            end else begin
                m_x = m_x - dri_pkg::OUT_W'(trig_delta(travel, c));
                m_y = m_y - dri_pkg::OUT_W'(trig_delta(travel, s));
            end
            m_path = m_path + dri_pkg::OUT_W'(travel);
        end else if (m_motion == dri_pkg::MOT_LEFT || m_motion == dri_pkg::MOT_RIGHT) begin
            dh = (64'(dt) * 64'(m_turn)) >> 16;
            if (m_motion == dri_pkg::MOT_LEFT) m_heading = m_heading + dh[31:0];
            else m_heading = m_heading - dh[31:0];
            m_turn_ms = m_turn_ms + dri_pkg::OUT_W'(dt);
        end
    endtask

    task automatic predict_pose(input t_request r);
        t_pose p;
        logic [79:0] u;
        case (r.op)
            dri_pkg::OP_UPDATE: integrate_motion(r.now_ms);
            dri_pkg::OP_SET: begin
                integrate_motion(r.now_ms);
                if (r.new_motion <= dri_pkg::MOT_RIGHT) m_motion = r.new_motion;
            end
            dri_pkg::OP_RESET: restart_pose(r.now_ms);
            default: ;
        endcase
        u = ((80'(m_drift) * 80'(m_path)) >> 16) + ((80'(m_tdrift) * 80'(m_turn_ms)) >> 16);
        p.x_pos = m_x; p.y_pos = m_y; p.heading = m_heading[31:16];
        p.path = m_path; p.turn_ms = m_turn_ms;
        p.unc = (u > 80'(48'hFFFF_FFFF_FFFF)) ? 48'hFFFF_FFFF_FFFF : u[47:0];
        p.motion = m_motion;
        expected_poses.push_back(p);
    endtask

    task automatic apply_setting(input logic [dri_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [31:0] d);
        case (idx)
            dri_pkg::REG_SPEED:  m_speed  = d[dri_pkg::SPEED_W-1:0];
            dri_pkg::REG_TURN:   m_turn   = d;
            dri_pkg::REG_DRIFT:  m_drift  = d[dri_pkg::DRIFT_W-1:0];
            default:             m_tdrift = d[dri_pkg::TDRIFT_W-1:0];
        endcase
        cfg_idx_q.push_back(idx);
        cfg_dat_q.push_back(d);
    endtask

    // Request driver
    int gap;
    initial begin
        item_ch.valid = 1'b0; item_ch.op = '0; item_ch.now_ms = '0; item_ch.new_motion = '0;
        gap = 0;
    end
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                predict_pose(t_request'{item_ch.op, item_ch.now_ms, item_ch.new_motion});
                n_accepted <= n_accepted + 1;
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (gap > 0 || pending_requests.size() == 0) begin
                    item_ch.valid <= 1'b0;
                    if (gap > 0) gap <= gap - 1;
                end else begin
                    t_request r;
                    r = pending_requests.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.op <= r.op;
                    item_ch.now_ms <= r.now_ms;
                    item_ch.new_motion <= r.new_motion;
                    gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                end
            end
        end
    end

    // Configuration driver
    initial begin
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    end
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!cfg_ch.valid || cfg_ch.ready) begin
                if (cfg_idx_q.size() > 0) begin
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= cfg_idx_q.pop_front();
                    cfg_ch.data  <= cfg_dat_q.pop_front();
                end else cfg_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure
    int hold;
    initial begin
        pose_ch.ready = 1'b0; hold = 0; stall_long = 0; n_errors = 0; n_accepted = 0;
    end
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pose_ch.valid && pose_ch.ready) begin
                t_pose got, want;
                got = t_pose'{pose_ch.x_position, pose_ch.y_position, pose_ch.heading_angle,
                              pose_ch.path_length, pose_ch.turn_time, pose_ch.uncertainty,
                              pose_ch.current_motion};
                if (expected_poses.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected pose %h", got);
                end else begin
                    want = expected_poses.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"pose mismatch: exp x=%h y=%h h=%h p=%h t=%h u=%h m=%h",
                                      " | got x=%h y=%h h=%h p=%h t=%h u=%h m=%h"},
                                     want.x_pos, want.y_pos, want.heading, want.path,
                                     want.turn_ms, want.unc, want.motion, got.x_pos,
                                     got.y_pos, got.heading, got.path, got.turn_ms,
                                     got.unc, got.motion);
                    end
                end
            end
            if (stall_long > 0) begin
                stall_long <= stall_long - 1;
                pose_ch.ready <= 1'b0;
            end else if (hold > 0) begin
                hold <= hold - 1;
                pose_ch.ready <= 1'b0;
            end else begin
                pose_ch.ready <= 1'b1;
                if (pose_ch.valid && pose_ch.ready)
                    hold <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
            end
        end
    end

    function automatic t_request make_req(logic [dri_pkg::OP_W-1:0] op, logic [31:0] t,
                                          logic [dri_pkg::MOTION_W-1:0] m);
        return t_request'{op, t, m};
    endfunction

    // Wait for the queued requests and expected poses to drain
    task automatic drain();
        while (pending_requests.size() > 0 || item_ch.valid || expected_poses.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Random journey: mostly small forward steps and motion changes, some odd times and codes
    task automatic journey(input int n);
        logic [31:0] t;
        int k;
        t = $urandom;
        pending_requests.push_back(make_req(dri_pkg::OP_RESET, t, dri_pkg::MOT_STOP));
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 3) t = t - $urandom_range(0, 100);
            else if (k < 6) t = t + 32'h7FFF_FFFF + $urandom_range(0, 2);
            else if (k < 10) t = t + $urandom;
            else if (k < 15) ;
            else t = t + $urandom_range(1, (k < 60) ? 500 : 200000);
            k = $urandom_range(0, 99);
            if (k < 45)
                pending_requests.push_back(make_req(dri_pkg::OP_UPDATE, t, 3'($urandom)));
            else if (k < 92)
                pending_requests.push_back(make_req(dri_pkg::OP_SET, t,
                    ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4))));
            else if (k < 96)
                pending_requests.push_back(make_req(dri_pkg::OP_RESET, t, 3'($urandom)));
            else
                pending_requests.push_back(make_req(dri_pkg::OP_NONE, $urandom, 3'($urandom)));
        end
    endtask

    initial begin
        m_speed = dri_pkg::SPEED_RST; m_turn = dri_pkg::TURN_RST;
        m_drift = dri_pkg::DRIFT_RST; m_tdrift = dri_pkg::TDRIFT_RST;
        m_x = '0; m_y = '0; m_path = '0; m_turn_ms = '0; m_heading = '0;
        m_last = '0; m_motion = dri_pkg::MOT_STOP; m_started = 1'b0;
        sending_done = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        // Directed: first request starts the clock, then every op and motion
        pending_requests.push_back(make_req(dri_pkg::OP_UPDATE, 32'hFFFF_FFF0, 3'd7));
        pending_requests.push_back(make_req(dri_pkg::OP_SET, 32'hFFFF_FFF0, dri_pkg::MOT_FWD));
        pending_requests.push_back(make_req(dri_pkg::OP_UPDATE, 32'h0000_0100, dri_pkg::MOT_STOP));
        pending_requests.push_back(make_req(dri_pkg::OP_SET, 32'h0000_0200, dri_pkg::MOT_LEFT));
        pending_requests.push_back(make_req(dri_pkg::OP_UPDATE, 32'h0000_4000, dri_pkg::MOT_STOP));
        pending_requests.push_back(make_req(dri_pkg::OP_SET, 32'h0000_5000, dri_pkg::MOT_BACK));
        pending_requests.push_back(make_req(dri_pkg::OP_UPDATE, 32'h0000_9000, dri_pkg::MOT_STOP));
        pending_requests.push_back(make_req(dri_pkg::OP_UPDATE, 32'h0000_8000, dri_pkg::MOT_STOP));
        pending_requests.push_back(make_req(dri_pkg::OP_SET, 32'h8000_9000, dri_pkg::MOT_RIGHT));
        pending_requests.push_back(make_req(dri_pkg::OP_SET, 32'h8000_8FFF, 3'd5));
        pending_requests.push_back(make_req(dri_pkg::OP_UPDATE, 32'h8001_0000, dri_pkg::MOT_STOP));
        pending_requests.push_back(make_req(dri_pkg::OP_SET, 32'h8001_0001, 3'd7));
        pending_requests.push_back(make_req(dri_pkg::OP_NONE, 32'hFFFF_FFFF, 3'd7));
        pending_requests.push_back(make_req(dri_pkg::OP_SET, 32'hFFFF_FFFF, dri_pkg::MOT_FWD));
        pending_requests.push_back(make_req(dri_pkg::OP_UPDATE, 32'h7FFF_FFFE, dri_pkg::MOT_STOP));
        pending_requests.push_back(make_req(dri_pkg::OP_RESET, 32'h0000_0000, dri_pkg::MOT_RIGHT));
        pending_requests.push_back(make_req(dri_pkg::OP_SET, 32'h0000_0000, dri_pkg::MOT_FWD));
        pending_requests.push_back(make_req(dri_pkg::OP_UPDATE, 32'h7FFF_FFFF, dri_pkg::MOT_STOP));
        drain();

        // Extreme rates: wrap accumulators and saturate uncertainty
        apply_setting(dri_pkg::REG_SPEED, 32'h000F_FFFF);
        apply_setting(dri_pkg::REG_TURN, 32'hFFFF_FFFF);
        apply_setting(dri_pkg::REG_DRIFT, 32'h0000_FFFF);
        apply_setting(dri_pkg::REG_TDRIFT, 32'h00FF_FFFF);
        repeat (10) @(posedge i_clk);
        pending_requests.push_back(make_req(dri_pkg::OP_RESET, 32'h0, dri_pkg::MOT_STOP));
        pending_requests.push_back(make_req(dri_pkg::OP_SET, 32'h0, dri_pkg::MOT_FWD));
        pending_requests.push_back(make_req(dri_pkg::OP_SET, 32'h7FFF_FFFF, dri_pkg::MOT_LEFT));
        pending_requests.push_back(make_req(dri_pkg::OP_SET, 32'hFFFF_FFFE, dri_pkg::MOT_BACK));
        pending_requests.push_back(make_req(dri_pkg::OP_SET, 32'h7FFF_FFFD, dri_pkg::MOT_RIGHT));
        pending_requests.push_back(make_req(dri_pkg::OP_UPDATE, 32'hFFFF_FFFC, dri_pkg::MOT_STOP));
        journey(300);
        drain();

        // Zero rates
        apply_setting(dri_pkg::REG_SPEED, 32'h0);
        apply_setting(dri_pkg::REG_TURN, 32'h0);
        apply_setting(dri_pkg::REG_DRIFT, 32'h0);
        apply_setting(dri_pkg::REG_TDRIFT, 32'h0);
        repeat (10) @(posedge i_clk);
        journey(100);
        drain();

        // Random settings phases, one with a long receiver stall
        for (int ph = 0; ph < 5; ph++) begin
            apply_setting(dri_pkg::REG_SPEED, $urandom);
            apply_setting(dri_pkg::REG_TURN, $urandom);
            apply_setting(dri_pkg::REG_DRIFT, $urandom);
            apply_setting(dri_pkg::REG_TDRIFT, $urandom);
            repeat (10) @(posedge i_clk);
            if (ph == 1) stall_long = 2000;
            journey(290);
            drain();
        end
        sending_done = 1;
    end

    // End of run
    initial begin
        wait (sending_done);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0 && expected_poses.size() == 0)
            $display("dead_reckoning_integrator_test: clean");
        else
            $display("dead_reckoning_integrator_test: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("dead_reckoning_integrator_test: errors");
        $finish;
    end
endmodule

FILE: sim.f
rtl/dri_pkg.sv
rtl/dri_if.sv
rtl/dri_datapath.sv
rtl/dri_ctrl.sv
rtl/dead_reckoning_integrator.sv
bench/dri_test_if.sv
bench/dead_reckoning_integrator_test.sv
